@@ rtl/cpp_pkg.sv @@
// Shared types, constants and helpers of the command packet parser.
// No dependencies; every other file but cpp_ram imports this package.
package cpp_pkg;

	localparam int PACKET_BYTES = 32;
	localparam int MAX_FIELDS   = 8;
	localparam int MAX_COMMANDS = 8;
	localparam int NAME_BYTES   = 16;

	localparam int PW = $clog2(PACKET_BYTES);
	localparam int FW = $clog2(MAX_FIELDS + 1);
	localparam int SW = $clog2(MAX_COMMANDS);
	localparam int NW = $clog2(NAME_BYTES);
	localparam int TW = SW + NW;

	localparam logic [7:0] CHAR_END   = 8'h3B;
	localparam logic [7:0] CHAR_SEP   = 8'h3A;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	localparam logic [1:0] ST_DISPATCHED   = 2'd0;
	localparam logic [1:0] ST_UNKNOWN_CMD  = 2'd1;
	localparam logic [1:0] ST_INVALID_ARGS = 2'd2;
	localparam logic [1:0] ST_TOO_LONG     = 2'd3;

	localparam logic ACT_STREAM = 1'b0;
	localparam logic ACT_TABLE  = 1'b1;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] byte_value;
		logic [2:0] table_slot;
		logic [3:0] table_position;
	} cmd_item_t;

	typedef struct packed {
		logic       item_kind;
		logic [1:0] status;
		logic [2:0] command_index;
		logic [3:0] field_count;
		logic [2:0] field_index;
		logic [7:0] payload_byte;
		logic       last;
	} result_item_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

endpackage

@@ rtl/cpp_cmd_if.sv @@
// Valid/ready channel interface for input items.
// Depends on cpp_pkg for the payload type.
interface cpp_cmd_if import cpp_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/cpp_result_if.sv @@
// Valid/ready channel interface for result items.
// Depends on cpp_pkg for the payload type.
interface cpp_result_if import cpp_pkg::*; ();
	logic         valid;
	logic         ready;
	result_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/command_packet_parser_core.sv @@
// Top level of the command packet parser: count register, sequencer, output register.
// Depends on cpp_pkg, cpp_cmd_if, cpp_result_if and cpp_seq.
//
// channel | dir | handshake   | payload
// cmd     | in  | valid/ready | action, byte_value, table_slot, table_position
// res     | out | valid/ready | item_kind, status, command_index, field_count,
//         |     |             | field_index, payload_byte, last
// cfg     | in  | cfg_we      | cfg_wdata = registered_count
//
// Stream bytes and table writes are accepted only while the sequencer is idle.
// A terminator scans the buffer byte by byte, then compares the name character by
// character against each table entry in turn, then emits the header and each
// payload byte, skipping separators.
// Reset clears all control state; both memories hold garbage until written.
// A stalled result channel holds the sequencer in its emit states.
module command_packet_parser_core import cpp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	cpp_cmd_if.sink      cmd,
	cpp_result_if.source res,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata
);
	logic [3:0]   count_q, limit;
	logic         emit_free, emit_valid;
	result_item_t emit_item, out_q;
	logic         out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	assign limit     = (count_q > 4'(MAX_COMMANDS)) ? 4'(MAX_COMMANDS) : count_q;
	assign emit_free = !out_valid_q || res.ready;

	cpp_seq u_seq (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .limit(limit),
		.emit_free(emit_free), .emit_valid(emit_valid), .emit_item(emit_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_free) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free && emit_valid) begin
			out_q <= emit_item;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;
endmodule

@@ rtl/cpp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/cpp_seq.sv @@
// Packet sequencer: buffers stream bytes, scans, matches names and emits results.
// Depends on cpp_pkg, cpp_cmd_if and cpp_ram.
module cpp_seq import cpp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cpp_cmd_if.sink       cmd,
	input  logic [3:0]    limit,
	input  logic          emit_free,
	output logic          emit_valid,
	output result_item_t  emit_item
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_SC_REQ = 8'b00000010,
		S_SC_USE = 8'b00000100,
		S_MT_REQ = 8'b00001000,
		S_MT_USE = 8'b00010000,
		S_HDR    = 8'b00100000,
		S_PL_REQ = 8'b01000000,
		S_PL_USE = 8'b10000000
	} state_t;

	state_t        state_q;
	logic [PW-1:0] fill_q, len_q, idx_q, end_q, nl_q, first_q, emitted_q, pcount_q;
	logic          disc_q;
	logic [FW-1:0] fields_q;
	logic [3:0]    slot_q;
	logic [1:0]    status_q;
	logic [2:0]    fi_q;
	logic [7:0]    pkt_rd, tbl_rd;
	logic          acc, pkt_we, tbl_we, pkt_re, tbl_re;
	logic [PW-1:0] pkt_raddr, nl_fin;
	logic [FW-1:0] fields_nx;
	logic [PW:0]   nl_ext;

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign pkt_we    = acc && cmd.payload.action == ACT_STREAM
		&& cmd.payload.byte_value != CHAR_END && !disc_q && fill_q != PW'(PACKET_BYTES - 1);
	assign tbl_we    = acc && cmd.payload.action == ACT_TABLE;
	assign pkt_re    = (state_q == S_SC_REQ) || (state_q == S_MT_REQ) || (state_q == S_PL_REQ);
	assign tbl_re    = (state_q == S_MT_REQ);
	assign pkt_raddr = idx_q;
	assign nl_ext    = {1'b0, nl_q};

	cpp_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt (
		.clk(clk), .we(pkt_we), .waddr(fill_q), .wdata(cmd.payload.byte_value),
		.re(pkt_re), .raddr(pkt_raddr), .rdata(pkt_rd)
	);

	cpp_ram #(.WIDTH(8), .DEPTH(MAX_COMMANDS * NAME_BYTES)) u_tbl (
		.clk(clk), .we(tbl_we),
		.waddr({cmd.payload.table_slot[SW-1:0], cmd.payload.table_position[NW-1:0]}),
		.wdata(cmd.payload.byte_value),
		.re(tbl_re), .raddr({slot_q[SW-1:0], idx_q[NW-1:0]}), .rdata(tbl_rd)
	);

	always_comb begin
		fields_nx = fields_q;
		if (pkt_rd == CHAR_SEP) begin
			fields_nx = fields_q + FW'(1);
		end
		nl_fin = (fields_nx == '0) ? ((pkt_rd == CHAR_NUL) ? idx_q : len_q) : nl_q;
		if (pkt_rd == CHAR_SEP && fields_q == '0) begin
			nl_fin = idx_q;
		end
	end

	always_comb begin
		emit_valid = 1'b0;
		emit_item  = '0;
		if (state_q == S_HDR && emit_free) begin
			emit_valid              = 1'b1;
			emit_item.item_kind     = KIND_HEADER;
			emit_item.status        = status_q;
			emit_item.command_index = (status_q == ST_DISPATCHED) ? slot_q[2:0] : 3'd0;
			emit_item.field_count   = (status_q == ST_DISPATCHED) ? fields_q : 4'd0;
			emit_item.last          = !(status_q == ST_DISPATCHED && pcount_q != '0);
		end else if (state_q == S_PL_USE && emit_free && pkt_rd != CHAR_SEP) begin
			emit_valid             = 1'b1;
			emit_item.item_kind    = KIND_PAYLOAD;
			emit_item.status       = ST_DISPATCHED;
			emit_item.field_index  = fi_q;
			emit_item.payload_byte = pkt_rd;
			emit_item.last         = (emitted_q + PW'(1) == pcount_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			disc_q    <= 1'b0;
			len_q     <= '0;
			idx_q     <= '0;
			end_q     <= '0;
			nl_q      <= '0;
			first_q   <= '0;
			emitted_q <= '0;
			pcount_q  <= '0;
			fields_q  <= '0;
			slot_q    <= '0;
			status_q  <= ST_DISPATCHED;
			fi_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc && cmd.payload.action == ACT_STREAM) begin
						if (cmd.payload.byte_value == CHAR_END) begin
							fill_q   <= '0;
							disc_q   <= 1'b0;
							len_q    <= fill_q;
							idx_q    <= '0;
							fields_q <= '0;
							nl_q     <= '0;
							if (disc_q) begin
								status_q <= ST_TOO_LONG;
								state_q  <= S_HDR;
							end else if (fill_q != '0) begin
								state_q <= S_SC_REQ;
							end
						end else if (pkt_we) begin
							fill_q <= fill_q + PW'(1);
						end else begin
							fill_q <= '0;
							disc_q <= 1'b1;
						end
					end
				end
				S_SC_REQ: state_q <= S_SC_USE;
				S_SC_USE: begin
					if (pkt_rd == CHAR_SEP && fields_q >= FW'(MAX_FIELDS)) begin
						status_q <= ST_INVALID_ARGS;
						state_q  <= S_HDR;
					end else if (pkt_rd == CHAR_NUL || idx_q == len_q - PW'(1)) begin
						end_q    <= (pkt_rd == CHAR_NUL) ? idx_q : len_q;
						fields_q <= fields_nx;
						nl_q     <= nl_fin;
						idx_q    <= '0;
						slot_q   <= '0;
						if (nl_fin == '0) begin
							state_q <= S_IDLE;
						end else if (limit == '0) begin
							status_q <= ST_UNKNOWN_CMD;
							state_q  <= S_HDR;
						end else begin
							state_q <= S_MT_REQ;
						end
					end else begin
						fields_q <= fields_nx;
						if (pkt_rd == CHAR_SEP && fields_q == '0) begin
							nl_q <= idx_q;
						end
						idx_q   <= idx_q + PW'(1);
						state_q <= S_SC_REQ;
					end
				end
				S_MT_REQ: state_q <= S_MT_USE;
				S_MT_USE: begin
					if (tbl_rd != CHAR_NUL && idx_q < nl_q && fold(tbl_rd) == fold(pkt_rd)
							&& idx_q != PW'(NAME_BYTES - 1)) begin
						idx_q   <= idx_q + PW'(1);
						state_q <= S_MT_REQ;
					end else if ((tbl_rd == CHAR_NUL && idx_q == nl_q)
							|| (tbl_rd != CHAR_NUL && idx_q < nl_q
							&& fold(tbl_rd) == fold(pkt_rd) && nl_ext == (PW+1)'(NAME_BYTES))) begin
						status_q <= ST_DISPATCHED;
						pcount_q <= end_q - nl_q - PW'(fields_q);
						state_q  <= S_HDR;
					end else if (slot_q + 4'd1 == limit) begin
						status_q <= ST_UNKNOWN_CMD;
						state_q  <= S_HDR;
					end else begin
						slot_q  <= slot_q + 4'd1;
						idx_q   <= '0;
						state_q <= S_MT_REQ;
					end
				end
				S_HDR: begin
					if (emit_free) begin
						idx_q     <= nl_q + PW'(1);
						first_q   <= nl_q;
						fi_q      <= '0;
						emitted_q <= '0;
						if (status_q == ST_DISPATCHED && pcount_q != '0) begin
							state_q <= S_PL_REQ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PL_REQ: state_q <= S_PL_USE;
				S_PL_USE: begin
					if (pkt_rd == CHAR_SEP) begin
						fi_q    <= fi_q + 3'd1;
						idx_q   <= idx_q + PW'(1);
						state_q <= S_PL_REQ;
					end else if (emit_free) begin
						emitted_q <= emitted_q + PW'(1);
						idx_q     <= idx_q + PW'(1);
						state_q   <= (emitted_q + PW'(1) == pcount_q) ? S_IDLE : S_PL_REQ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid |-> (state_q == S_HDR || state_q == S_PL_USE))
		else $error("result produced outside header or payload state");
	a_fields_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fields_q <= FW'(MAX_FIELDS))
		else $error("field count above limit");
	a_disc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> fill_q == '0)
		else $error("discarding with bytes held");
	a_payload_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PL_USE) |-> idx_q > first_q)
		else $error("payload read inside the name");
endmodule
